@@ design/random_permutation_slot_picker_macros.svh @@
// ---------------------------------------------------------------------------
// random_permutation_slot_picker_macros
// Assertion shorthands shared by the permutation slot picker modules.
// ---------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_SLOT_PICKER_MACROS_SVH
`define RANDOM_PERMUTATION_SLOT_PICKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RPSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define RPSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/rpsp_pkg.sv @@
// ---------------------------------------------------------------------------
// rpsp_pkg
// Types and fixed widths shared by the permutation slot picker.
// ---------------------------------------------------------------------------
`default_nettype none

package rpsp_pkg;

  localparam int DRAW_W  = 31;   // random draw word
  localparam int LEN_W   = 7;    // length register
  localparam int OUT_W   = 6;    // slot and value outputs
  localparam int CHUNK_W = 8;    // free slots scanned per cycle
  localparam int POS_W   = 3;    // bit position inside one chunk
  localparam int PC_W    = 4;    // population count of one chunk

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEL,
    ST_OUT
  } st_t;

  // Head of the draw queue as seen by the back end
  typedef struct packed {
    logic              valid;
    logic [DRAW_W-1:0] draw;
  } rpsp_job_t;

endpackage

`default_nettype wire

@@ design/rpsp_front.sv @@
// ---------------------------------------------------------------------------
// rpsp_front
// Accepts draw words, trims them to the used width and queues them.
// ---------------------------------------------------------------------------
`default_nettype none
`include "random_permutation_slot_picker_macros.svh"

module rpsp_front #(
  parameter int DRAW_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rpsp_pkg::DRAW_W-1:0] in_random_draw,
  output rpsp_pkg::rpsp_job_t       job_o,
  input  logic                      pop_i
);
  import rpsp_pkg::*;

  localparam logic [DRAW_W-1:0] DRAW_MASK = (DRAW_BITS >= DRAW_W) ? {DRAW_W{1'b1}} :
                                            DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

  logic [DRAW_W-1:0] mem_r [0:1];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  assign job_o.valid = (cnt_r != 2'd0);
  assign job_o.draw  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop_i) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_i && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Drop the unused high draw bits on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_random_draw & DRAW_MASK;
    end
  end

  `RPSP_ASSERT(a_cnt_range, cnt_r != 2'd3, "draw queue count out of range")
  `RPSP_ASSERT(a_pop_nonempty, pop_i |-> (cnt_r != 2'd0), "pop from empty draw queue")
  `RPSP_ASSERT(a_push_shows, (push && cnt_r == 2'd0) |=> job_o.valid,
               "queued draw not presented")

endmodule

`default_nettype wire

@@ design/rpsp_back.sv @@
// ---------------------------------------------------------------------------
// rpsp_back
// Reduces each draw modulo the free slot count, picks that free slot,
// updates the slot mask and registers the result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "random_permutation_slot_picker_macros.svh"

module rpsp_back #(
  parameter int PERM_MAX  = 64,
  parameter int DRAW_BITS = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpsp_pkg::rpsp_job_t        job_i,
  output logic                       pop_o,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rpsp_pkg::LEN_W-1:0] cfg_perm_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rpsp_pkg::OUT_W-1:0] out_slot_index,
  output logic [rpsp_pkg::OUT_W-1:0] out_placed_value,
  output logic                       out_last_of_perm
);
  import rpsp_pkg::*;

  localparam int USE_BITS = (DRAW_BITS > DRAW_W) ? DRAW_W : DRAW_BITS;
  localparam int BIT_CW   = (USE_BITS > 1) ? $clog2(USE_BITS) : 1;
  localparam int CNT_W    = $clog2(PERM_MAX + 1);
  localparam int SLOT_W   = $clog2(PERM_MAX);
  localparam int NCHUNK   = (PERM_MAX + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W    = NCHUNK * CHUNK_W;
  localparam int LW       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CMP_W    = (CNT_W > PC_W) ? CNT_W : PC_W;

  st_t                 st_r, st_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [PERM_MAX-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [USE_BITS-1:0] dr_r, dr_nxt;
  logic [BIT_CW-1:0]   bit_r, bit_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    d_r, d_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_slot_r, out_value_r;
  logic                out_last_r;

  logic              cfg_wr;
  logic              div_step, sel_step, out_load;
  logic              div_done;
  logic [LW-1:0]     len_x;
  logic [CNT_W-1:0]  n_eff;
  logic              start_clear;
  logic [CNT_W:0]    trial;
  logic [PAD_W-1:0]  free_pad;
  logic [CHUNK_W-1:0] chunk;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   seen;
  logic [POS_W-1:0]  pos;
  logic              found;
  logic              hit;
  logic [CH_W+POS_W-1:0] slot_full;
  logic [CNT_W-1:0]  cnt_inc;
  logic              last;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  // Clamp the length register to 1..PERM_MAX
  always_comb begin
    len_x = LW'(len_r);
    if (len_x == '0) begin
      n_eff = CNT_W'(1);
    end else if (len_x > LW'(PERM_MAX)) begin
      n_eff = CNT_W'(PERM_MAX);
    end else begin
      n_eff = CNT_W'(len_x);
    end
  end

  assign start_clear = (cnt_r >= n_eff);
  assign div_done    = (bit_r == '0);

  // One restoring division step per cycle, remainder only
  assign trial = {rem_r, dr_r[USE_BITS-1]};

  // Scan one chunk of free slots per cycle
  assign free_pad = PAD_W'(free_r);
  assign chunk    = free_pad[{ch_r, POS_W'(0)} +: CHUNK_W];

  always_comb begin
    pc    = '0;
    seen  = '0;
    pos   = '0;
    found = 1'b0;
    for (int b = 0; b < CHUNK_W; b++) begin
      if (chunk[b]) begin
        if (!found && seen == PC_W'(k_r)) begin
          pos   = POS_W'(b);
          found = 1'b1;
        end
        seen = seen + PC_W'(1);
        pc   = pc + PC_W'(1);
      end
    end
  end

  assign hit       = (CMP_W'(k_r) < CMP_W'(pc));
  assign slot_full = {ch_r, pos};
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign last      = (cnt_inc == n_eff);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_i.valid) st_nxt = ST_DIV;
      ST_DIV:  if (div_done) st_nxt = ST_SEL;
      ST_SEL:  if (hit) st_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    div_step = 1'b0;
    sel_step = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: pop_o    = job_i.valid;
      ST_DIV:  div_step = 1'b1;
      ST_SEL:  sel_step = 1'b1;
      ST_OUT:  out_load = !out_valid_r || out_ready;
      default: pop_o    = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    len_nxt  = len_r;
    free_nxt = free_r;
    cnt_nxt  = cnt_r;
    dr_nxt   = dr_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    k_nxt    = k_r;
    ch_nxt   = ch_r;
    slot_nxt = slot_r;

    if (pop_o) begin
      dr_nxt  = job_i.draw[USE_BITS-1:0];
      bit_nxt = BIT_CW'(USE_BITS - 1);
      rem_nxt = '0;
      if (start_clear) begin
        free_nxt = '1;
        cnt_nxt  = '0;
        d_nxt    = n_eff;
      end else begin
        d_nxt    = n_eff - cnt_r;
      end
    end

    if (div_step) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, d_r});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      dr_nxt  = dr_r << 1;
      bit_nxt = bit_r - BIT_CW'(1);
      if (div_done) begin
        k_nxt  = rem_nxt;
        ch_nxt = '0;
      end
    end

    if (sel_step) begin
      if (hit) begin
        slot_nxt = slot_full[SLOT_W-1:0];
      end else begin
        k_nxt  = k_r - CNT_W'(pc);
        ch_nxt = ch_r + CH_W'(1);
      end
    end

    if (out_load) begin
      free_nxt[slot_r] = 1'b0;
      cnt_nxt          = cnt_inc;
      if (last) begin
        free_nxt = '1;
        cnt_nxt  = '0;
      end
    end

    // A length write starts a fresh permutation
    if (cfg_wr) begin
      len_nxt  = cfg_perm_length;
      free_nxt = '1;
      cnt_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      len_r       <= LEN_RESET;
      free_r      <= '1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dr_r   <= dr_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    k_r    <= k_nxt;
    ch_r   <= ch_nxt;
    slot_r <= slot_nxt;
    if (out_load) begin
      out_slot_r  <= OUT_W'(slot_r);
      out_value_r <= OUT_W'(cnt_r);
      out_last_r  <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_placed_value = out_value_r;
  assign out_last_of_perm = out_last_r;

  `RPSP_ASSERT(a_slot_free, (st_r == ST_OUT) |-> free_r[slot_r], "picked slot is not free")
  `RPSP_ASSERT(a_cnt_below_n, cnt_r < n_eff, "placed count reached length")
  `RPSP_ASSERT(a_last_clears, (out_load && last) |=> (cnt_r == '0 && free_r == '1),
               "state not cleared after last value")
  `RPSP_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

@@ design/random_permutation_slot_picker.sv @@
// ---------------------------------------------------------------------------
// random_permutation_slot_picker
// Builds random permutations of perm_length values, one value per draw word.
// Input channel: in_valid/in_ready/in_random_draw, one draw word per value.
// Output channel: out_valid/out_ready with slot index, placed value and a
// last flag on the word that completes the permutation.
// Config channel: cfg_valid/cfg_ready/cfg_perm_length, always ready; a write
// restarts the permutation. Write it only while no word is in flight.
// Throughput is set by the bit-serial remainder loop (one draw bit a cycle)
// and the free-slot scan (eight slots a cycle); the back end finishes one
// word before it pops the next. A two-word draw queue keeps in_ready high
// while the back end works, until both queue entries are full.
// Reset: length 64, all slots free, no result pending; no clearing pass.
// A stalled receiver holds the result register; the back end then waits
// with its next pick and the queue fills before in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module random_permutation_slot_picker #(
  parameter int PERM_MAX  = 64,
  parameter int DRAW_BITS = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rpsp_pkg::DRAW_W-1:0] in_random_draw,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rpsp_pkg::LEN_W-1:0] cfg_perm_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rpsp_pkg::OUT_W-1:0] out_slot_index,
  output logic [rpsp_pkg::OUT_W-1:0] out_placed_value,
  output logic                       out_last_of_perm
);
  import rpsp_pkg::*;

  // Queue head and pop between front and back
  rpsp_job_t job;
  logic      pop;

  // Front: accept draw words, trim to DRAW_BITS, hold them in the queue
  rpsp_front #(
    .DRAW_BITS (DRAW_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_random_draw (in_random_draw),
    .job_o          (job),
    .pop_i          (pop)
  );

  // Back: remainder, slot pick, mask update and result register
  rpsp_back #(
    .PERM_MAX  (PERM_MAX),
    .DRAW_BITS (DRAW_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_i            (job),
    .pop_o            (pop),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_perm_length  (cfg_perm_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_index   (out_slot_index),
    .out_placed_value (out_placed_value),
    .out_last_of_perm (out_last_of_perm)
  );

endmodule

`default_nettype wire
